@@ hw/rtl/nsc_pkg.sv @@
// Shared constants and helper functions for the NMEA sentence checker.
// Holds default parameters, verdict and kind codes, and character decoders.
// Depends on nothing.
`default_nettype none

package nsc_pkg;

  // Default line limits
  localparam int MAX_LINE_DEF = 120;
  localparam int MIN_LINE_DEF = 6;

  // Verdict codes
  localparam logic [1:0] ST_ACCEPT   = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_NO_STAR  = 2'd2;
  localparam logic [1:0] ST_MISMATCH = 2'd3;

  // Sentence kind codes
  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_RMC   = 2'd1;
  localparam logic [1:0] KIND_GGA   = 2'd2;

  // Characters of interest
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;

  // Address tails
  localparam logic [23:0] TAIL_RMC = 24'h524D43;
  localparam logic [23:0] TAIL_GGA = 24'h474741;

  // Space, tab, LF, VT, FF and CR
  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Read two checksum characters with strtoul-style sign and blank rules
  function automatic logic [7:0] parse_sum(input logic [15:0] chars);
    logic [4:0] h0;
    logic [4:0] h1;
    logic [7:0] r;
    h0 = hex_value(chars[15:8]);
    h1 = hex_value(chars[7:0]);
    r  = 8'd0;
    if (is_blank(chars[15:8]) || chars[15:8] == CH_PLUS) begin
      r = h1[4] ? {4'd0, h1[3:0]} : 8'd0;
    end else if (chars[15:8] == CH_MINUS) begin
      r = h1[4] ? (8'd0 - {4'd0, h1[3:0]}) : 8'd0;
    end else if (h0[4]) begin
      r = h1[4] ? {h0[3:0], h1[3:0]} : {4'd0, h0[3:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/nmea_sentence_checker_unit.sv @@
// Top level of the NMEA sentence checker: per-byte line tracking and verdict.
// Depends on nsc_pkg for codes, limits and character decoders.
//
// Usage: feed received bytes on rx_byte with in_valid/in_ready. Each CR or
// LF that closes a non-empty line yields one verdict transaction on the
// output channel (status, sentence_kind, computed_sum, received_sum) with
// out_valid/out_ready. Other bytes, empty line ends and overflowing bytes
// give no transaction.
// Throughput: one byte per cycle while no verdict is held. All per-byte
// state updates and the final verdict are a single short combinational
// step off the line state. The verdict is in the output register in the
// cycle after the line end byte is accepted.
// Stall: the output register holds the verdict while out_ready is low, and
// in_ready stays low for every byte until that verdict is taken; a byte is
// accepted in the same cycle that the waiting verdict leaves.
// Reset: rst (synchronous) clears the line state and drops any held verdict.
`default_nettype none

module nmea_sentence_checker_unit #(
  parameter int MAX_LINE = nsc_pkg::MAX_LINE_DEF,
  parameter int MIN_LINE = nsc_pkg::MIN_LINE_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      status,
  output logic [1:0]      sentence_kind,
  output logic [7:0]      computed_sum,
  output logic [7:0]      received_sum
);
  import nsc_pkg::*;

  localparam int CNT_W = $clog2(MAX_LINE + 1);

  // Line state
  logic [CNT_W-1:0] raw_count;
  logic             lead_seen;
  logic             start_is_dollar;
  logic             star_seen;
  logic [7:0]       running_xor;
  logic [CNT_W-1:0] kept_length;
  logic [CNT_W-1:0] pending_length;
  logic [CNT_W-1:0] after_star_kept;
  logic [CNT_W-1:0] after_star_pending;
  logic [15:0]      sum_chars;
  logic             address_done;
  logic [23:0]      address_tail;

  logic             in_fire;
  logic             is_end;
  logic             ws;
  logic             overflow;
  logic [CNT_W-1:0] after_star_n;

  logic [1:0]       status_next;
  logic [1:0]       kind_next;
  logic [7:0]       comp_next;
  logic [7:0]       recv_next;
  logic [7:0]       parsed_sum;

  assign in_ready     = !out_valid || out_ready;
  assign in_fire      = in_valid && in_ready;
  assign is_end       = (rx_byte == CH_CR) || (rx_byte == CH_LF);
  assign ws           = is_blank(rx_byte);
  assign overflow     = (raw_count >= CNT_W'(MAX_LINE));
  assign after_star_n = after_star_kept + after_star_pending;
  assign parsed_sum   = parse_sum(sum_chars);

  // Form the verdict for the line as it stands
  always_comb begin
    status_next = ST_SHORT;
    kind_next   = KIND_OTHER;
    comp_next   = 8'd0;
    recv_next   = 8'd0;
    if (!lead_seen || (32'(kept_length) < MIN_LINE) || !start_is_dollar) begin
      status_next = ST_SHORT;
    end else if (!star_seen || (after_star_kept < CNT_W'(2))) begin
      status_next = ST_NO_STAR;
    end else begin
      comp_next   = running_xor;
      recv_next   = parsed_sum;
      status_next = (running_xor == parsed_sum) ? ST_ACCEPT : ST_MISMATCH;
      if (running_xor == parsed_sum) begin
        if (address_tail == TAIL_RMC) begin
          kind_next = KIND_RMC;
        end else if (address_tail == TAIL_GGA) begin
          kind_next = KIND_GGA;
        end
      end
    end
  end

  // Output register: drop on take, load on a closed line
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_fire && is_end && (raw_count != '0)) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_end && (raw_count != '0)) begin
      status        <= status_next;
      sentence_kind <= kind_next;
      computed_sum  <= comp_next;
      received_sum  <= recv_next;
    end
  end

  // Advance the line state for each accepted byte
  always_ff @(posedge clk) begin
    if (rst || (in_fire && (is_end || overflow))) begin
      raw_count          <= '0;
      lead_seen          <= 1'b0;
      start_is_dollar    <= 1'b0;
      star_seen          <= 1'b0;
      running_xor        <= 8'd0;
      kept_length        <= '0;
      pending_length     <= '0;
      after_star_kept    <= '0;
      after_star_pending <= '0;
      sum_chars          <= 16'd0;
      address_done       <= 1'b0;
      address_tail       <= 24'd0;
    end else if (in_fire) begin
      raw_count <= raw_count + CNT_W'(1);
      if (!lead_seen) begin
        if (!ws) begin
          lead_seen       <= 1'b1;
          start_is_dollar <= (rx_byte == CH_DOLLAR);
          kept_length     <= CNT_W'(1);
          pending_length  <= '0;
        end
      end else begin
        // Track trimmed length of the whole line
        if (ws) begin
          pending_length <= pending_length + CNT_W'(1);
        end else begin
          kept_length    <= kept_length + pending_length + CNT_W'(1);
          pending_length <= '0;
        end
        if (!star_seen) begin
          // Accumulate checksum and address field
          if (rx_byte == CH_STAR) begin
            star_seen    <= 1'b1;
            address_done <= 1'b1;
          end else begin
            running_xor <= running_xor ^ rx_byte;
            if (!address_done) begin
              if (rx_byte == CH_COMMA) begin
                address_done <= 1'b1;
              end else begin
                address_tail <= {address_tail[15:0], rx_byte};
              end
            end
          end
        end else begin
          // Capture the two checksum characters and trimmed tail length
          if (after_star_n == '0) begin
            sum_chars <= {rx_byte, 8'd0};
          end else if (after_star_n == CNT_W'(1)) begin
            sum_chars <= {sum_chars[15:8], rx_byte};
          end
          if (ws) begin
            after_star_pending <= after_star_pending + CNT_W'(1);
          end else begin
            after_star_kept    <= after_star_kept + after_star_pending + CNT_W'(1);
            after_star_pending <= '0;
          end
        end
      end
    end
  end

`ifndef SYNTHESIS
  // Line byte count never exceeds its limit
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    raw_count <= CNT_W'(MAX_LINE))
    else $error("line count beyond limit");

  // A line end always restarts the line
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && is_end) |=> (raw_count == '0 && !lead_seen && !star_seen))
    else $error("line state not cleared at line end");

  // Only accepted lines carry a sentence kind
  a_kind_only_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_ACCEPT) |-> (sentence_kind == KIND_OTHER))
    else $error("sentence kind on rejected line");

  // Format failures report zero sums
  a_zero_sums: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_SHORT || status == ST_NO_STAR))
      |-> (computed_sum == 8'd0 && received_sum == 8'd0))
    else $error("sums reported on malformed line");
`endif

endmodule

`default_nettype wire
